// ----- rtl/xsie_pkg.sv -----
package xsie_pkg;

   // stack geometry: eight byte-wide banks, one row holds one byte of each bank
   localparam int STACK_BYTES = 4096;
   localparam int IDX_W       = $clog2(STACK_BYTES);
   localparam int ROW_W       = IDX_W - 3;
   localparam int ROWS        = STACK_BYTES / 8;

   // control from the executor to the stack memory
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic             clr;
      logic [IDX_W-1:0] rd_idx;
      logic [IDX_W-1:0] wr_idx;
   } stk_ctl_type;

endpackage

// ----- rtl/xsie_stack.sv -----
module xsie_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  xsie_pkg::stk_ctl_type ctl,
   input  logic [63:0]           wr_data,
   output logic [63:0]           rd_data,
   output logic                  clr_busy
);
   import xsie_pkg::*;

   logic             clr_act_ff, clr_act_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;
   logic [2:0]       off_ff;
   logic [7:0]       bank_q [8];

   // clearing sweep, one row of all banks per cycle
   always_comb begin
      clr_act_in = clr_act_ff;
      clr_row_in = clr_row_ff;
      if (clr_act_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            clr_act_in = 1'b0;
         end
      end
      if (ctl.clr) begin
         clr_act_in = 1'b1;
         clr_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_act_ff <= 1'b1;
         clr_row_ff <= '0;
      end else begin
         clr_act_ff <= clr_act_in;
         clr_row_ff <= clr_row_in;
      end
   end

   assign clr_busy = clr_act_ff;

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         off_ff <= ctl.rd_idx[2:0];
      end
   end

   for (genvar b = 0; b < 8; b++) begin : gen_bank
      logic [7:0]       mem [ROWS];
      logic [7:0]       q_ff;
      logic [ROW_W-1:0] rrow, wrow;
      logic [2:0]       wsel;
      logic [7:0]       wbyte;

      // a bank below the start offset holds its byte in the next row
      always_comb begin
         rrow  = ctl.rd_idx[IDX_W-1:3] + ROW_W'(3'(b) < ctl.rd_idx[2:0]);
         wrow  = ctl.wr_idx[IDX_W-1:3] + ROW_W'(3'(b) < ctl.wr_idx[2:0]);
         wsel  = 3'(b) - ctl.wr_idx[2:0];
         wbyte = wr_data[8*wsel +: 8];
      end

      always_ff @(posedge clock) begin
         if (clr_act_ff) begin
            mem[clr_row_ff] <= '0;
         end else if (ctl.wr_en) begin
            mem[wrow] <= wbyte;
         end
         if (ctl.rd_en) begin
            q_ff <= mem[rrow];
         end
      end

      assign bank_q[b] = q_ff;
   end

   // rotate bank outputs back into little-endian byte order
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rd_data[8*i +: 8] = bank_q[3'(i) + off_ff];
      end
   end

endmodule

// ----- rtl/x86_subset_instruction_executor_unit.sv -----
// x86 subset executor: runs one pre-decoded instruction per input transfer
// against eight 64-bit registers, a zero flag and a 4 KiB byte stack.
// req channel: tuser[0] is the opcode (0 start a run, 1 execute), tdata carries
//   the run arguments, the first seven instruction bytes, length and decoder marks.
// rsp channel: one transfer per request with the status and, on return, eax.
// an item is accepted in one cycle and executed in the next, where the stack
//   word read in the accept cycle comes back from the banked stack ram; the
//   result lands in an output register at the end of the execute cycle.
// a new item is not accepted while the last one executes, owing to the
//   read-then-writeback of the register file and stack ram; a held result does
//   not block the next accept when the receiver takes it in the same cycle.
// reset clears registers and flag and starts a stack clearing sweep over all
//   512 rows (one row of all eight banks per cycle); a start item runs the same
//   sweep, and no request is taken while it runs.
// when rsp_tready stays low the output register holds its result and
//   req_tready drops until the result is taken.
module x86_subset_instruction_executor_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // arg_first, arg_second, insn_bytes, insn_length, named_nop, is_return,
   // jmp_mark, jcc_mark
   input  logic [191:0] req_tdata,
   // opcode
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, return_value, zero fill
   output logic [39:0]  rsp_tdata
);
   import xsie_pkg::*;

   localparam logic [2:0] ST_CONT   = 3'd0;
   localparam logic [2:0] ST_RET    = 3'd1;
   localparam logic [2:0] ST_BRANCH = 3'd2;
   localparam logic [2:0] ST_FAULT  = 3'd3;
   localparam logic [2:0] ST_UNSUP  = 3'd4;

   localparam logic [2:0] R_AX = 3'd0;
   localparam logic [2:0] R_CX = 3'd1;
   localparam logic [2:0] R_SP = 3'd4;
   localparam logic [2:0] R_BP = 3'd5;
   localparam logic [2:0] R_SI = 3'd6;
   localparam logic [2:0] R_DI = 3'd7;

   localparam logic       OP_START = 1'b0;
   localparam logic [63:0] STK_LAST = 64'(STACK_BYTES - 8);
   localparam logic [63:0] STK_TOP  = 64'(STACK_BYTES);
   localparam logic [63:0] RUN_SP   = 64'h800;

   // instruction bytes
   localparam logic [7:0] OPB_NOP    = 8'h90;
   localparam logic [7:0] OPB_OSIZE  = 8'h66;
   localparam logic [7:0] OPB_ESC    = 8'h0F;
   localparam logic [7:0] OPB_NOPL   = 8'h1F;
   localparam logic [7:0] OPB_REXW   = 8'h48;
   localparam logic [7:0] OPB_XCHG   = 8'h87;
   localparam logic [7:0] OPB_MODRAX = 8'hC0;
   localparam logic [7:0] OPB_RET    = 8'hC3;
   localparam logic [7:0] OPB_PUSH   = 8'h50;
   localparam logic [7:0] OPB_POP    = 8'h58;
   localparam logic [7:0] OPB_PUSHI  = 8'h6A;
   localparam logic [7:0] OPB_MOVI   = 8'hB8;
   localparam logic [7:0] OPB_MOVIM  = 8'hC7;
   localparam logic [7:0] OPB_XOR    = 8'h31;
   localparam logic [7:0] OPB_SUB    = 8'h29;
   localparam logic [7:0] OPB_MOV    = 8'h89;
   localparam logic [7:0] OPB_LOAD   = 8'h8B;
   localparam logic [7:0] OPB_ADD    = 8'h01;
   localparam logic [7:0] OPB_FROMDI = 8'hF8;
   localparam logic [7:0] OPB_FROMSI = 8'hF0;
   localparam logic [7:0] OPB_GRP5   = 8'hFF;
   localparam logic [7:0] OPB_DECRAX = 8'hC8;
   localparam logic [7:0] OPB_GRP1S  = 8'h83;
   localparam logic [7:0] OPB_GRP1L  = 8'h81;
   localparam logic [7:0] OPB_RMECX  = 8'hF9;
   localparam logic [7:0] OPB_SUBRSP = 8'hEC;
   localparam logic [7:0] OPB_ADDRSP = 8'hC4;
   localparam logic [7:0] OPB_RBPRSP = 8'hE5;
   localparam logic [7:0] OPB_LEAVE  = 8'hC9;
   localparam logic [7:0] OPB_SIBNOD = 8'h04;
   localparam logic [7:0] OPB_SIBD8  = 8'h44;
   localparam logic [7:0] OPB_SIBRSP = 8'h24;
   localparam logic [7:0] OPB_LEA    = 8'h8D;
   localparam logic [7:0] OPB_LEAMOD = 8'h00;

   typedef enum logic [4:0] {
      K_NONE, K_START, K_PUSH, K_PUSHI, K_POP, K_MOVI, K_CLR, K_MOVEAX,
      K_INCDEC, K_CMP, K_SPSUB, K_SPADD, K_MOVBP, K_MOVSP, K_LEAVE,
      K_STORE, K_LOAD, K_RET, K_JCC
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [2:0]       status;
      logic [2:0]       rsel;
      logic             flag;
      logic [IDX_W-1:0] idx;
      logic [63:0]      val_a;
      logic [63:0]      val_b;
   } op_type;

   // request fields
   logic        opcode;
   logic [63:0] arg_first, arg_second;
   logic [55:0] insn_bytes;
   logic [3:0]  insn_length;
   logic        named_nop, is_return, jmp_mark, jcc_mark;
   logic [7:0]  b0, b1, b2, b3, b4;

   assign opcode      = req_tuser[0];
   assign arg_first   = req_tdata[63:0];
   assign arg_second  = req_tdata[127:64];
   assign insn_bytes  = req_tdata[183:128];
   assign insn_length = req_tdata[187:184];
   assign named_nop   = req_tdata[188];
   assign is_return   = req_tdata[189];
   assign jmp_mark    = req_tdata[190];
   assign jcc_mark    = req_tdata[191];
   assign b0 = insn_bytes[7:0];
   assign b1 = insn_bytes[15:8];
   assign b2 = insn_bytes[23:16];
   assign b3 = insn_bytes[31:24];
   assign b4 = insn_bytes[39:32];

   // state
   logic [63:0] regs_ff [8];
   logic [63:0] regs_in [8];
   logic        zf_ff, zf_in;
   logic        exe_ff;
   op_type      op_ff, dec;
   logic        out_v_ff;
   logic [39:0] out_d_ff;

   // stack interface
   stk_ctl_type stk_ctl;
   logic [63:0] stk_wdata, stk_rdata;
   logic        stk_busy;

   logic        accept;
   logic [63:0] sp, bp, sp_m8, disp_idx;
   logic        push_ok, pop_ok, nop_form, rd_kind;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = !exe_ff && !stk_busy && (!out_v_ff || rsp_tready);

   assign sp       = regs_ff[R_SP];
   assign bp       = regs_ff[R_BP];
   assign sp_m8    = sp - 64'd8;
   assign push_ok  = (sp >= 64'd8) && (sp <= STK_TOP);
   assign pop_ok   = (sp <= STK_LAST);
   assign disp_idx = (b2 == OPB_SIBNOD) ? sp : sp + {{56{b4[7]}}, b4};

   assign nop_form = (b0 == OPB_NOP) ||
                     (insn_length >= 4'd2 && b0 == OPB_OSIZE && b1 == OPB_NOP) ||
                     (insn_length >= 4'd3 && b0 == OPB_ESC && b1 == OPB_NOPL) ||
                     (insn_length >= 4'd3 && b0 == OPB_REXW && b1 == OPB_XCHG &&
                      b2 == OPB_MODRAX) ||
                     (insn_length >= 4'd2 && b0 == OPB_XCHG && b1 == OPB_MODRAX) ||
                     named_nop;

   // decode in the accept cycle, against the registers the last item left
   always_comb begin
      dec        = '0;
      dec.kind   = K_NONE;
      dec.status = ST_CONT;
      if (opcode == OP_START) begin
         dec.kind  = K_START;
         dec.val_a = arg_first;
         dec.val_b = arg_second;
      end else if (insn_length == 4'd0 || nop_form) begin
         dec.kind = K_NONE;
      end else if (is_return || b0 == OPB_RET) begin
         dec.kind = K_RET;
      end else if (b0[7:3] == OPB_PUSH[7:3] && insn_length == 4'd1) begin
         // push reg
         dec.rsel = b0[2:0];
         dec.idx  = sp_m8[IDX_W-1:0];
         if (push_ok) dec.kind = K_PUSH;
         else         dec.status = ST_FAULT;
      end else if (b0[7:3] == OPB_POP[7:3] && insn_length == 4'd1) begin
         // pop reg
         dec.rsel = b0[2:0];
         dec.idx  = sp[IDX_W-1:0];
         if (pop_ok) dec.kind = K_POP;
         else        dec.status = ST_FAULT;
      end else if (b0 == OPB_PUSHI && insn_length >= 4'd2) begin
         dec.val_a = {{56{b1[7]}}, b1};
         dec.idx   = sp_m8[IDX_W-1:0];
         if (push_ok) dec.kind = K_PUSHI;
         else         dec.status = ST_FAULT;
      end else if (b0[7:3] == OPB_MOVI[7:3] && insn_length >= 4'd5) begin
         dec.kind  = K_MOVI;
         dec.rsel  = b0[2:0];
         dec.val_a = {32'd0, insn_bytes[39:8]};
      end else if (insn_length >= 4'd7 && b0 == OPB_REXW && b1 == OPB_MOVIM &&
                   b2 == OPB_MODRAX) begin
         dec.kind  = K_MOVI;
         dec.rsel  = R_AX;
         dec.val_a = {32'd0, insn_bytes[55:24]};
      end else if (insn_length >= 4'd3 && b0 == OPB_REXW &&
                   (b1 == OPB_XOR || b1 == OPB_SUB) &&
                   b2[7:6] == 2'b11 && b2[2:0] == b2[5:3]) begin
         dec.kind = K_CLR;
         dec.rsel = b2[2:0];
      end else if (insn_length >= 4'd2 && b0 == OPB_XOR && b1[7:6] == 2'b11 &&
                   b1[2:0] == b1[5:3]) begin
         dec.kind = K_CLR;
         dec.rsel = b1[2:0];
      end else if (insn_length >= 4'd2 && (b0 == OPB_MOV || b0 == OPB_ADD) &&
                   (b1 == OPB_FROMDI || b1 == OPB_FROMSI)) begin
         dec.kind = K_MOVEAX;
         dec.rsel = (b1 == OPB_FROMDI) ? R_DI : R_SI;
         dec.flag = (b0 == OPB_ADD);
      end else if (insn_length >= 4'd3 && b0 == OPB_REXW && b1 == OPB_GRP5 &&
                   (b2 == OPB_MODRAX || b2 == OPB_DECRAX)) begin
         dec.kind = K_INCDEC;
         dec.flag = (b2 == OPB_DECRAX);
      end else if (insn_length >= 4'd3 && b0 == OPB_GRP1S && b1 == OPB_RMECX) begin
         dec.kind  = K_CMP;
         dec.val_a = {{56{b2[7]}}, b2};
      end else if (insn_length >= 4'd6 && b0 == OPB_GRP1L && b1 == OPB_RMECX) begin
         dec.kind  = K_CMP;
         dec.val_a = {32'd0, insn_bytes[47:16]};
      end else if (insn_length >= 4'd4 && b0 == OPB_REXW && b1 == OPB_GRP1S &&
                   b2 == OPB_SUBRSP) begin
         dec.kind  = K_SPSUB;
         dec.val_a = {56'd0, b3};
      end else if (insn_length >= 4'd4 && b0 == OPB_REXW && b1 == OPB_GRP1S &&
                   b2 == OPB_ADDRSP) begin
         dec.kind  = K_SPADD;
         dec.val_a = {56'd0, b3};
      end else if (insn_length >= 4'd3 && b0 == OPB_REXW && b1 == OPB_MOV &&
                   b2 == OPB_RBPRSP) begin
         dec.kind = K_MOVBP;
      end else if (insn_length >= 4'd3 && b0 == OPB_REXW && b1 == OPB_MOV &&
                   b2 == OPB_SUBRSP) begin
         dec.kind = K_MOVSP;
      end else if (b0 == OPB_LEAVE) begin
         // leave: reload rbp from the frame
         dec.idx = bp[IDX_W-1:0];
         if (bp <= STK_LAST) dec.kind = K_LEAVE;
         else                dec.status = ST_FAULT;
      end else if (insn_length >= 4'd4 && b0 == OPB_REXW &&
                   (b1 == OPB_MOV || b1 == OPB_LOAD) &&
                   (b2 == OPB_SIBNOD || b2 == OPB_SIBD8) && b3 == OPB_SIBRSP &&
                   (b2 == OPB_SIBNOD || insn_length >= 4'd5)) begin
         // [rsp] or [rsp+disp8] with rax
         dec.idx = disp_idx[IDX_W-1:0];
         if (disp_idx > STK_LAST)  dec.status = ST_FAULT;
         else if (b1 == OPB_MOV)   dec.kind = K_STORE;
         else                      dec.kind = K_LOAD;
      end else if (insn_length >= 4'd3 && b0 == OPB_REXW && b1 == OPB_LEA &&
                   b2 == OPB_LEAMOD) begin
         dec.kind = K_NONE;
      end else if (jmp_mark) begin
         dec.status = ST_BRANCH;
      end else if (jcc_mark) begin
         dec.kind = K_JCC;
      end else begin
         dec.status = ST_UNSUP;
      end
   end

   assign rd_kind = (dec.kind == K_POP) || (dec.kind == K_LEAVE) || (dec.kind == K_LOAD);

   // execute cycle: stack word is back, compute writeback and result
   logic [2:0]  ex_status;
   logic [31:0] ex_rv;
   logic        ex_wr, ex_clr;
   logic [63:0] src_sum, sp_ex;

   assign sp_ex   = regs_ff[R_SP];
   assign src_sum = regs_ff[op_ff.rsel] + (op_ff.flag ? regs_ff[R_AX] : 64'd0);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         regs_in[i] = regs_ff[i];
      end
      zf_in     = zf_ff;
      ex_status = op_ff.status;
      ex_rv     = '0;
      ex_wr     = 1'b0;
      ex_clr    = 1'b0;
      stk_wdata = regs_ff[R_AX];
      unique case (op_ff.kind)
         K_START: begin
            for (int i = 0; i < 8; i++) begin
               regs_in[i] = '0;
            end
            regs_in[R_DI] = op_ff.val_a;
            regs_in[R_SI] = op_ff.val_b;
            regs_in[R_SP] = RUN_SP;
            regs_in[R_BP] = RUN_SP;
            zf_in         = 1'b0;
            ex_clr        = 1'b1;
         end
         K_PUSH: begin
            regs_in[R_SP] = sp_ex - 64'd8;
            stk_wdata     = (op_ff.rsel == R_SP) ? sp_ex - 64'd8 : regs_ff[op_ff.rsel];
            ex_wr         = 1'b1;
         end
         K_PUSHI: begin
            regs_in[R_SP] = sp_ex - 64'd8;
            stk_wdata     = op_ff.val_a;
            ex_wr         = 1'b1;
         end
         K_POP: begin
            // pop of rsp takes the loaded value and then steps past it
            regs_in[op_ff.rsel] = stk_rdata;
            regs_in[R_SP]       = regs_in[R_SP] + 64'd8;
         end
         K_MOVI:   regs_in[op_ff.rsel] = op_ff.val_a;
         K_CLR: begin
            regs_in[op_ff.rsel] = '0;
            zf_in               = 1'b1;
         end
         K_MOVEAX: regs_in[R_AX] = {32'd0, src_sum[31:0]};
         K_INCDEC: begin
            if (op_ff.flag) regs_in[R_AX] = {32'd0, regs_ff[R_AX][31:0] - 32'd1};
            else            regs_in[R_AX] = {32'd0, regs_ff[R_AX][31:0] + 32'd1};
         end
         K_CMP:    zf_in = (regs_ff[R_CX][31:0] == op_ff.val_a[31:0]);
         K_SPSUB:  regs_in[R_SP] = sp_ex - op_ff.val_a;
         K_SPADD:  regs_in[R_SP] = sp_ex + op_ff.val_a;
         K_MOVBP:  regs_in[R_BP] = sp_ex;
         K_MOVSP:  regs_in[R_SP] = regs_ff[R_BP];
         K_LEAVE: begin
            regs_in[R_BP] = stk_rdata;
            regs_in[R_SP] = regs_ff[R_BP] + 64'd8;
         end
         K_STORE:  ex_wr = 1'b1;
         K_LOAD:   regs_in[R_AX] = stk_rdata;
         K_RET: begin
            ex_status = ST_RET;
            ex_rv     = regs_ff[R_AX][31:0];
         end
         K_JCC:    ex_status = zf_ff ? ST_BRANCH : ST_CONT;
         K_NONE:   ex_status = op_ff.status;
         default:  ex_status = ST_UNSUP;
      endcase
   end

   always_comb begin
      stk_ctl        = '0;
      stk_ctl.rd_en  = accept && rd_kind;
      stk_ctl.rd_idx = dec.idx;
      stk_ctl.wr_en  = exe_ff && ex_wr;
      stk_ctl.wr_idx = op_ff.idx;
      stk_ctl.clr    = exe_ff && ex_clr;
   end

   xsie_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctl      (stk_ctl),
      .wr_data  (stk_wdata),
      .rd_data  (stk_rdata),
      .clr_busy (stk_busy)
   );

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= '0;
         end
         zf_ff    <= 1'b0;
         exe_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         exe_ff <= accept;
         if (exe_ff) begin
            for (int i = 0; i < 8; i++) begin
               regs_ff[i] <= regs_in[i];
            end
            zf_ff    <= zf_in;
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= dec;
      end
      if (exe_ff) begin
         out_d_ff <= {5'd0, ex_rv, ex_status};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

endmodule
